/* src/group_reverse_stream_core_defines.svh */
// Assertion macros shared by the group reverse stream design.
`ifndef GROUP_REVERSE_STREAM_CORE_DEFINES_SVH
`define GROUP_REVERSE_STREAM_CORE_DEFINES_SVH

// Overlapping implication, checked at every rising clock edge outside reset.
`define GRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grs: implication check failed");

// Non-overlapping implication: the consequent is checked in the cycle after the antecedent.
`define GRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grs: next-cycle check failed");

`endif

/* src/grs_pkg.sv */
// Package with the shared constants, types and helpers of the group reverse stream.
package grs_pkg;

    // Largest group the buffer can hold.
    localparam int MAX_GROUP = 64;

    // Widths derived from the buffer depth.
    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CW = $clog2(MAX_GROUP + 1);

    // Field widths of the channels and the configuration register.
    localparam int VALUE_W = 32;
    localparam int GS_W    = 7;
    localparam int KW      = (CW > GS_W) ? CW : GS_W;

    // Configuration port geometry.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes.
    localparam logic [PADDR_W-3:0] REG_GROUP_SIZE = '0;

    // Reset value of the group size register.
    localparam logic [GS_W-1:0] GROUP_SIZE_RST = GS_W'(1);

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_seq_state;

    // Request from the sequencer to the group buffer.
    typedef struct packed {
        logic               we;
        logic [AW-1:0]      waddr;
        logic [VALUE_W-1:0] wdata;
        logic               re;
        logic [AW-1:0]      raddr;
    } t_ram_req;

    // Group size as used by the datapath: zero acts as one, large values saturate.
    function automatic logic [KW-1:0] effective_size(input logic [GS_W-1:0] gs);
        logic [KW-1:0] gs_ext;
        logic [KW-1:0] k;
        gs_ext = KW'(gs);
        if (gs_ext == '0) begin
            k = KW'(1);
        end else if (gs_ext > KW'(MAX_GROUP)) begin
            k = KW'(MAX_GROUP);
        end else begin
            k = gs_ext;
        end
        return k;
    endfunction

endpackage

/* src/grs_if.sv */
// Stream interfaces for the input values and the reordered results.
interface grs_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [grs_pkg::VALUE_W-1:0] value;
    logic                              end_of_list;

    modport source (output valid, output value, output end_of_list, input ready);
    modport sink   (input valid, input value, input end_of_list, output ready);
endinterface

interface grs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [grs_pkg::VALUE_W-1:0] out_value;
    logic                              last_of_run;
    logic                              list_done;

    modport source (output valid, output out_value, output last_of_run, output list_done,
                    input ready);
    modport sink   (input valid, input out_value, input last_of_run, input list_done,
                    output ready);
endinterface

/* src/grs_ram.sv */
// Simple dual-port synchronous RAM with a registered, enabled read port.
module grs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: the data register holds its value while the read is not enabled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/grs_cfg.sv */
// APB-style register block holding the group size.
module grs_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [grs_pkg::PADDR_W-1:0]   paddr,
    input  logic [grs_pkg::PDATA_W-1:0]   pwdata,
    output logic [grs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [grs_pkg::GS_W-1:0]      o_group_size
);

    logic [grs_pkg::GS_W-1:0] r_group_size;
    logic                     wr_en;
    logic                     sel_gs;

    // Word index decode: the low two address bits select bytes and are ignored.
    assign sel_gs = (paddr[grs_pkg::PADDR_W-1:2] == grs_pkg::REG_GROUP_SIZE);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Group size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= grs_pkg::GROUP_SIZE_RST;
        end else if (wr_en && sel_gs) begin
            r_group_size <= pwdata[grs_pkg::GS_W-1:0];
        end
    end

    // Read-back multiplexer; unmapped addresses read as zero.
    always_comb begin
        if (sel_gs) begin
            prdata = grs_pkg::PDATA_W'(r_group_size);
        end else begin
            prdata = '0;
        end
    end

    assign o_group_size = r_group_size;

endmodule

/* src/grs_seq.sv */
// Sequencer: fills the group buffer and drives the read-out of each group.
`include "group_reverse_stream_core_defines.svh"

module grs_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [grs_pkg::GS_W-1:0]          i_group_size,
    grs_in_if.sink                            i_in,
    grs_out_if.source                         o_res,
    output grs_pkg::t_ram_req                 o_ram_req,
    input  logic [grs_pkg::VALUE_W-1:0]       i_rdata
);

    grs_pkg::t_seq_state         r_state, n_state;
    logic [grs_pkg::AW-1:0]      r_fill,  n_fill;
    logic [grs_pkg::AW-1:0]      r_addr,  n_addr;
    logic [grs_pkg::CW-1:0]      r_rem,   n_rem;
    logic                        r_rev,   n_rev;
    logic                        r_eol,   n_eol;
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_last,  n_out_last;
    logic                        r_out_done,  n_out_done;

    logic [grs_pkg::KW-1:0]      k_eff;
    logic [grs_pkg::KW-1:0]      n_held;
    logic                        accept;
    logic                        group_full;
    logic                        issue;

    // Group size in force and the number of values held once this transaction is stored.
    assign k_eff      = grs_pkg::effective_size(i_group_size);
    assign n_held     = grs_pkg::KW'(r_fill) + grs_pkg::KW'(1);
    assign group_full = (n_held >= k_eff);

    assign i_in.ready = (r_state == grs_pkg::ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    // A read may go out when the result register is empty or being taken.
    assign issue      = !r_out_valid || o_res.ready;

    // Next state, buffer accesses and result register control.
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_addr      = r_addr;
        n_rem       = r_rem;
        n_rev       = r_rev;
        n_eol       = r_eol;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;

        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_fill;
        o_ram_req.wdata = i_in.value;
        o_ram_req.re    = 1'b0;
        o_ram_req.raddr = r_addr;

        unique case (r_state)
            grs_pkg::ST_IDLE: begin
                if (r_out_valid && o_res.ready) begin
                    n_out_valid = 1'b0;
                end
                if (accept) begin
                    o_ram_req.we = 1'b1;
                    n_eol        = i_in.end_of_list;
                    if (group_full) begin
                        // Full group: read back from the newest entry downwards.
                        n_rev   = 1'b1;
                        n_addr  = r_fill;
                        n_rem   = grs_pkg::CW'(n_held);
                        n_fill  = '0;
                        n_state = grs_pkg::ST_DRAIN;
                    end else if (i_in.end_of_list) begin
                        // Short final group: read back in arrival order.
                        n_rev   = 1'b0;
                        n_addr  = '0;
                        n_rem   = grs_pkg::CW'(n_held);
                        n_fill  = '0;
                        n_state = grs_pkg::ST_DRAIN;
                    end else begin
                        n_fill  = grs_pkg::AW'(n_held);
                    end
                end
            end
            grs_pkg::ST_DRAIN: begin
                if (issue) begin
                    o_ram_req.re = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_last   = (r_rem == grs_pkg::CW'(1));
                    n_out_done   = (r_rem == grs_pkg::CW'(1)) && r_eol;
                    n_rem        = r_rem - grs_pkg::CW'(1);
                    if (r_rev) begin
                        n_addr = r_addr - grs_pkg::AW'(1);
                    end else begin
                        n_addr = r_addr + grs_pkg::AW'(1);
                    end
                    if (r_rem == grs_pkg::CW'(1)) begin
                        n_state = grs_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = grs_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= grs_pkg::ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // Read sequencing and result side-band registers.
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_rem      <= n_rem;
        r_rev      <= n_rev;
        r_eol      <= n_eol;
        r_out_last <= n_out_last;
        r_out_done <= n_out_done;
    end

    // Result channel: the value comes straight from the buffer's read register.
    assign o_res.valid       = r_out_valid;
    assign o_res.out_value   = i_rdata;
    assign o_res.last_of_run = r_out_last;
    assign o_res.list_done   = r_out_done;

    // A drain always has reads outstanding.
    `GRS_ASSERT_IMP(a_drain_nonempty, i_clk, i_rst_n,
        r_state == grs_pkg::ST_DRAIN, r_rem != '0)
    // The end-of-list mark only ever comes with the last result of a run.
    `GRS_ASSERT_IMP(a_done_is_last, i_clk, i_rst_n,
        r_out_valid && r_out_done, r_out_last)
    // A completed or final group starts a drain of exactly the values held.
    `GRS_ASSERT_NXT(a_drain_start, i_clk, i_rst_n,
        accept && (group_full || i_in.end_of_list),
        r_state == grs_pkg::ST_DRAIN && r_rem == grs_pkg::CW'($past(n_held)))
    // Any other transaction only grows the fill count.
    `GRS_ASSERT_NXT(a_fill_grows, i_clk, i_rst_n,
        accept && !group_full && !i_in.end_of_list,
        r_state == grs_pkg::ST_IDLE && r_fill == $past(r_fill) + grs_pkg::AW'(1))

endmodule

/* src/group_reverse_stream_core.sv */
// Top level of the group reverse stream: register block, sequencer and group buffer.
//
// Usage: values arrive on i_in, one per transaction, with end_of_list set on the
// final value of a list. Results leave on o_res. The group size is written through
// the APB-style port at address 0; it resets to 1. The user must write it only while
// the block is idle; the block itself does not enforce this. Values are stored in a
// 64-entry buffer until a group of group_size is held; the group then leaves in
// reverse order. A short group at the end of a list leaves in arrival order.
// last_of_run marks the final result caused by one input transaction and list_done
// the final result of a list. After the transaction that completes a group is taken,
// the sequencer enters its drain state and starts the read; the first result is
// valid once the buffer's read register is loaded, and the others follow one per cycle
// while the receiver takes them. Filling and reading out a group take turns, and the
// group buffer has a single read port. i_in is not ready while a group is read out.
// Reset clears the fill count and the control state; the buffer needs no clearing
// pass, since only entries written in the current group are read.
// When the receiver stalls, the pending result holds and the read-out pauses.
module group_reverse_stream_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    grs_in_if.sink                        i_in,
    grs_out_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [grs_pkg::PADDR_W-1:0]   paddr,
    input  logic [grs_pkg::PDATA_W-1:0]   pwdata,
    output logic [grs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [grs_pkg::GS_W-1:0]    group_size;
    grs_pkg::t_ram_req           ram_req;
    logic [grs_pkg::VALUE_W-1:0] rdata;

    // Configuration registers.
    grs_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_group_size (group_size)
    );

    // Fill and read-out control.
    grs_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_group_size (group_size),
        .i_in         (i_in),
        .o_res        (o_res),
        .o_ram_req    (ram_req),
        .i_rdata      (rdata)
    );

    // Group buffer.
    grs_ram #(
        .DEPTH (grs_pkg::MAX_GROUP),
        .WIDTH (grs_pkg::VALUE_W)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

endmodule
